// File: design/wrapped_trigger_counter_expander_core_macros.svh
// Assertion macros shared by the trigger counter expander RTL.
// Included by files that carry concurrent checks; expects a clk and rst in scope.
`ifndef WRAPPED_TRIGGER_COUNTER_EXPANDER_CORE_MACROS_SVH
`define WRAPPED_TRIGGER_COUNTER_EXPANDER_CORE_MACROS_SVH
// Property that must hold in the same cycle.
`define TWCE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Implication: the consequent must hold in the cycle after the antecedent.
`define TWCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/twce_pkg.sv
// Package for the trigger counter expander: codes, history entry type, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package twce_pkg;
  localparam int HIST_DEPTH = 64;
  localparam int HIST_MIN = 64;
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W = $clog2(HIST_DEPTH);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 48;
  localparam int IN_DATA_W = 152;
  localparam int OUT_DATA_W = 184;

  localparam logic [CFG_IDX_W-1:0] REG_REORDER_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_CONFIRM = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [2:0] OUT_IN_ORDER = 3'd0;
  localparam logic [2:0] OUT_DUPLICATE = 3'd1;
  localparam logic [2:0] OUT_LATE_ACC = 3'd2;
  localparam logic [2:0] OUT_LATE_REJ = 3'd3;
  localparam logic [2:0] OUT_DONE = 3'd4;

  localparam logic [1:0] CONF_RELATIVE = 2'd0;
  localparam logic [1:0] CONF_UNKNOWN = 2'd1;
  localparam logic [1:0] CONF_CONFIRMED = 2'd2;

  localparam logic [1:0] RSN_NONE = 2'd0;
  localparam logic [1:0] RSN_IDLE = 2'd1;
  localparam logic [1:0] RSN_RESET = 2'd2;
  localparam logic [1:0] RSN_HALF = 2'd3;

  typedef struct packed {
    logic [15:0] wval;
    logic [63:0] pos;
  } entry_t;

  typedef struct packed {
    logic push;
    logic rot;
  } chain_ctrl_t;

  function automatic logic [FILL_W-1:0] hist_limit(input logic [4:0] win);
    logic [4:0] ew;
    logic [FILL_W-1:0] l;
    ew = (win == 5'd0) ? 5'd1 : win;
    l = FILL_W'({ew, 2'b00});
    if (l < FILL_W'(HIST_MIN)) l = FILL_W'(HIST_MIN);
    if (l > FILL_W'(HIST_DEPTH)) l = FILL_W'(HIST_DEPTH);
    return l;
  endfunction
endpackage
`default_nettype wire

// File: design/wrapped_trigger_counter_expander_core.sv
// Trigger counter expander top level: control, round state and history chain.
// Depends on twce_pkg, twce_cell and the assertion macro header.
//
// Use: input words arrive on s_tvalid/s_tready with the opcode in s_tuser;
// one result word leaves on m_tvalid/m_tready for every input word, in order.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
// A result is registered once its word is evaluated; a backward step first searches
// the 64-cell history chain, rotated past the head comparator one cell a cycle.
// The next word is taken once the last result is registered, while it may still
// wait in the output register; a stalled receiver holds the block only when
// a second result is ready.
// Reset clears the round state, the history fill count and the output valid flag;
// history cells hold no reset value and are read only where filled.
`timescale 1ns / 1ps
`default_nettype none
`include "wrapped_trigger_counter_expander_core_macros.svh"
module wrapped_trigger_counter_expander_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // wire_trigger, timestamp_ns, metadata_lost, absolute_start, close_reason,
  // force_unknown, zero fill
  input  wire logic [twce_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode
  input  wire logic [1:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // new_round, reset_suspected, metadata_dropped, round_number, expanded_position,
  // confidence, round_reason, round_start, round_end, round_unknown_epoch
  output logic [twce_pkg::OUT_DATA_W-1:0]       m_tdata,
  // outcome
  output logic [2:0]                            m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [twce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [twce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import twce_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_RESOLVE = 2'd3;

  logic [1:0] state, state_next;
  logic [4:0] reorder_window;
  logic [4:0] win_eff;
  logic [47:0] idle_timeout_ns;

  logic [1:0] op;
  logic [15:0] w;
  logic [63:0] t;
  logic lost;
  logic [63:0] abs_start;
  logic [1:0] close_reason;
  logic force_unknown;

  logic [31:0] round_counter, round_counter_next;
  logic anchored, anchored_next;
  logic [15:0] last_wire, last_wire_next;
  logic [63:0] last_pos, last_pos_next;
  logic [63:0] last_seen, last_seen_next;
  logic [63:0] start_cand, start_cand_next;
  logic [15:0] end_cand, end_cand_next;
  logic [1:0] conf, conf_next;
  logic [1:0] open_reason, open_reason_next;
  logic epoch_unknown, epoch_unknown_next;
  logic [FILL_W-1:0] fill, fill_next, fill_base;

  logic [IDX_W-1:0] k;
  logic found;
  logic [63:0] found_pos;
  logic md_saved;

  logic out_free, commit, backward, timed_out, unk;
  logic [15:0] diff, mag;
  logic [31:0] rc_inc;
  logic [63:0] fwd_pos;
  logic push_req;
  entry_t push_entry;
  chain_ctrl_t ctrl;
  entry_t cells [HIST_DEPTH];

  logic [2:0] r_outcome;
  logic r_nr, r_rs, r_md;
  logic [63:0] r_pos;

  assign s_tready = (state == S_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;
  assign diff = w - last_wire;
  assign mag = 16'd0 - diff;
  assign win_eff = (reorder_window == 5'd0) ? 5'd1 : reorder_window;
  assign rc_inc = (round_counter == 32'hFFFF_FFFF) ? 32'd1 : round_counter + 32'd1;
  assign fwd_pos = last_pos + {48'd0, diff};
  assign timed_out = anchored && (idle_timeout_ns != 48'd0) && (t > last_seen)
                     && ((t - last_seen) > {16'd0, idle_timeout_ns});
  assign backward = (op == OP_OBSERVE) && anchored && !timed_out && diff[15];

  always_comb begin
    round_counter_next = round_counter;
    anchored_next = anchored;
    last_wire_next = last_wire;
    last_pos_next = last_pos;
    last_seen_next = last_seen;
    start_cand_next = start_cand;
    end_cand_next = end_cand;
    conf_next = conf;
    open_reason_next = open_reason;
    epoch_unknown_next = epoch_unknown;
    fill_base = fill;
    push_req = 1'b0;
    push_entry = '{wval: w, pos: 64'd0};
    r_outcome = OUT_DONE;
    r_nr = 1'b0;
    r_rs = 1'b0;
    r_md = 1'b0;
    r_pos = 64'd0;
    unk = 1'b0;
    commit = 1'b0;
    case (state)
      S_EVAL: begin
        commit = out_free && !backward;
        if (op == OP_CONFIRM) begin
          if (anchored) begin
            start_cand_next = abs_start;
            conf_next = CONF_CONFIRMED;
            epoch_unknown_next = 1'b0;
          end
        end else if (op == OP_CLOSE) begin
          unk = force_unknown || (close_reason == RSN_RESET) || (close_reason == RSN_HALF);
          round_counter_next = rc_inc;
          start_cand_next = 64'd0;
          end_cand_next = 16'd0;
          conf_next = unk ? CONF_UNKNOWN : CONF_RELATIVE;
          open_reason_next = close_reason;
          epoch_unknown_next = unk;
          anchored_next = 1'b0;
          fill_base = '0;
        end else if (op == OP_OBSERVE) begin
          if (timed_out) begin
            round_counter_next = rc_inc;
            start_cand_next = 64'd0;
            end_cand_next = 16'd0;
            conf_next = CONF_RELATIVE;
            open_reason_next = RSN_IDLE;
            epoch_unknown_next = 1'b0;
            fill_base = '0;
            r_nr = 1'b1;
          end
          if (lost) begin
            conf_next = CONF_UNKNOWN;
            epoch_unknown_next = 1'b1;
            r_md = 1'b1;
          end
          if (!anchored || timed_out) begin
            anchored_next = 1'b1;
            last_wire_next = w;
            last_pos_next = 64'd0;
            start_cand_next = {48'd0, w};
            end_cand_next = w;
            push_req = 1'b1;
            last_seen_next = t;
            r_outcome = OUT_IN_ORDER;
          end else if (diff == 16'd0) begin
            r_outcome = OUT_DUPLICATE;
            r_pos = last_pos;
            if (t > last_seen) last_seen_next = t;
          end else if (!diff[15]) begin
            last_pos_next = fwd_pos;
            last_wire_next = w;
            end_cand_next = w;
            push_req = 1'b1;
            push_entry = '{wval: w, pos: fwd_pos};
            r_outcome = OUT_IN_ORDER;
            r_pos = fwd_pos;
            if (t > last_seen) last_seen_next = t;
          end
        end
      end
      S_RESOLVE: begin
        commit = out_free;
        r_md = md_saved;
        if (found) begin
          r_outcome = OUT_LATE_ACC;
          r_pos = found_pos;
        end else if ((diff == 16'h8000) || (mag > {11'd0, win_eff})) begin
          round_counter_next = rc_inc;
          conf_next = CONF_UNKNOWN;
          open_reason_next = (diff == 16'h8000) ? RSN_HALF : RSN_RESET;
          epoch_unknown_next = 1'b1;
          fill_base = '0;
          anchored_next = 1'b1;
          last_wire_next = w;
          last_pos_next = 64'd0;
          start_cand_next = {48'd0, w};
          end_cand_next = w;
          push_req = 1'b1;
          last_seen_next = t;
          r_nr = 1'b1;
          r_rs = 1'b1;
          r_outcome = OUT_IN_ORDER;
        end else if ({48'd0, mag} <= last_pos) begin
          r_pos = last_pos - {48'd0, mag};
          push_req = 1'b1;
          push_entry = '{wval: w, pos: last_pos - {48'd0, mag}};
          r_outcome = OUT_LATE_ACC;
        end else begin
          r_outcome = OUT_LATE_REJ;
        end
      end
      default: begin
        commit = 1'b0;
      end
    endcase
    if (push_req) begin
      fill_next = (fill_base >= hist_limit(reorder_window)) ? hist_limit(reorder_window)
                                                           : fill_base + FILL_W'(1);
    end else begin
      fill_next = fill_base;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_EVAL;
      S_EVAL: begin
        if (backward) state_next = S_SEARCH;
        else if (out_free) state_next = S_IDLE;
      end
      S_SEARCH: if (k == IDX_W'(HIST_DEPTH - 1)) state_next = S_RESOLVE;
      S_RESOLVE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign ctrl.push = commit && push_req;
  assign ctrl.rot = (state == S_SEARCH);

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_chain
    twce_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .push_in ((i == 0) ? push_entry : cells[(i + HIST_DEPTH - 1) % HIST_DEPTH]),
      .rot_in  (cells[(i + 1) % HIST_DEPTH]),
      .q       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reorder_window <= 5'd8;
      idle_timeout_ns <= 48'd0;
      round_counter <= 32'd1;
      anchored <= 1'b0;
      last_wire <= 16'd0;
      last_pos <= 64'd0;
      last_seen <= 64'd0;
      start_cand <= 64'd0;
      end_cand <= 16'd0;
      conf <= CONF_RELATIVE;
      open_reason <= RSN_NONE;
      epoch_unknown <= 1'b0;
      fill <= '0;
      m_tvalid <= 1'b0;
      k <= '0;
      found <= 1'b0;
      md_saved <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_REORDER_WINDOW: reorder_window <= cfg_data[4:0];
          REG_IDLE_TIMEOUT: idle_timeout_ns <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_IDLE && s_tvalid) begin
        op <= s_tuser;
        w <= s_tdata[15:0];
        t <= s_tdata[79:16];
        lost <= s_tdata[80];
        abs_start <= s_tdata[144:81];
        close_reason <= s_tdata[146:145];
        force_unknown <= s_tdata[147];
      end
      if (state == S_EVAL && backward) begin
        md_saved <= lost;
        if (lost) begin
          conf <= CONF_UNKNOWN;
          epoch_unknown <= 1'b1;
        end
        k <= '0;
        found <= 1'b0;
      end
      if (state == S_SEARCH) begin
        k <= k + IDX_W'(1);
        if (!found && (FILL_W'(k) < fill) && (cells[0].wval == w)) begin
          found <= 1'b1;
          found_pos <= cells[0].pos;
        end
      end
      if (commit) begin
        round_counter <= round_counter_next;
        anchored <= anchored_next;
        last_wire <= last_wire_next;
        last_pos <= last_pos_next;
        last_seen <= last_seen_next;
        start_cand <= start_cand_next;
        end_cand <= end_cand_next;
        conf <= conf_next;
        open_reason <= open_reason_next;
        epoch_unknown <= epoch_unknown_next;
        fill <= fill_next;
        m_tvalid <= 1'b1;
        m_tuser <= r_outcome;
        m_tdata <= {epoch_unknown_next, end_cand_next, start_cand_next, open_reason_next,
                    conf_next, r_pos, round_counter_next, r_md, r_rs, r_nr};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `TWCE_ASSERT(a_fill_bound, fill <= FILL_W'(HIST_DEPTH), "history fill above depth")
  `TWCE_ASSERT(a_round_nonzero, round_counter != 32'd0, "round counter is zero")
  `TWCE_ASSERT_NEXT(a_search_end, state == S_SEARCH && k == IDX_W'(HIST_DEPTH - 1),
                    state == S_RESOLVE, "search did not end after a full rotation")
endmodule
`default_nettype wire

// File: design/twce_cell.sv
// One history cell: holds a wire/position pair, shifts toward older on push
// and rotates toward the head during a search. Depends on twce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module twce_cell (
  input  wire logic                 clk,
  input  wire twce_pkg::chain_ctrl_t ctrl,
  input  wire twce_pkg::entry_t     push_in,
  input  wire twce_pkg::entry_t     rot_in,
  output twce_pkg::entry_t          q
);
  import twce_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= push_in;
    end else if (ctrl.rot) begin
      q <= rot_in;
    end
  end
endmodule
`default_nettype wire
